// ----- rtl/core/sbb_pkg.sv -----
`default_nettype none

package sbb_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned PIX_MAX = (1 << PIX_W) - 1;

endpackage

`default_nettype wire

// ----- rtl/core/sbb_ram.sv -----
`default_nettype none

module sbb_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/separable_box_blur_6x6.sv -----
// Causal separable box blur over a square grey frame.
// Input channel: in_valid_i / in_stall_o with pixel_i and frame_start_i; a pixel
// transfers at a rising edge with in_valid_i high and in_stall_o low. Pixels come
// in raster order; frame_start_i marks row 0, column 0 and restarts the position.
// Output channel: out_valid_o / out_stall_i with blurred_pixel_o, one result per
// input pixel, in input order.
// Throughput: one pixel per clock while the receiver does not stall. A result passes
// through four register stages (sum and line read, horizontal divide, vertical sum
// and line write-back, vertical divide into the output register).
// Each column keeps WINDOW_TAPS-1 row averages in one word of a single-port-pair
// line memory (FRAME_SIDE words), read at input and written back from stage two.
// When the receiver stalls a valid result, the result register holds and the
// whole pipeline freezes; in_stall_o follows at once. Reset clears the position,
// the recent pixels and all valid flags; the line memory needs no clearing, since
// row 0 overwrites every slot of its column before any of them is used.
`default_nettype none

module separable_box_blur_6x6 #(
  parameter int unsigned FRAME_SIDE  = 256,
  parameter int unsigned WINDOW_TAPS = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [sbb_pkg::PIX_W-1:0]  pixel_i,
  input  wire logic                       frame_start_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [sbb_pkg::PIX_W-1:0]  blurred_pixel_o
);

  localparam int unsigned PW          = sbb_pkg::PIX_W;
  localparam int unsigned PREV_TAPS   = WINDOW_TAPS - 1;
  localparam int unsigned COL_W       = $clog2(FRAME_SIDE);
  localparam int unsigned SLOT_W      = (PREV_TAPS > 1) ? $clog2(PREV_TAPS) : 1;
  localparam int unsigned SUM_W       = $clog2(WINDOW_TAPS * sbb_pkg::PIX_MAX + 1);
  localparam int unsigned RECIP_SHIFT = SUM_W + $clog2(WINDOW_TAPS);
  localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + WINDOW_TAPS - 1) / WINDOW_TAPS;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  localparam int unsigned LINE_W      = PREV_TAPS * PW;

  logic en;
  logic accept;

  logic [COL_W-1:0]  col_pos_q, col_pos_d;
  logic [COL_W-1:0]  row_pos_q, row_pos_d;
  logic [SLOT_W-1:0] slot_pos_q, slot_pos_d;
  logic [COL_W-1:0]  col_eff, row_eff;
  logic [SLOT_W-1:0] slot_eff;
  logic              col_zero;

  logic [PW-1:0]     recent_q [PREV_TAPS];
  logic [PW-1:0]     recent_d [PREV_TAPS];
  logic [SUM_W-1:0]  hsum_d;

  logic              s1_valid_q;
  logic [SUM_W-1:0]  s1_hsum_q;
  logic [COL_W-1:0]  s1_col_q;
  logic              s1_row0_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic [PROD_W-1:0] s1_prod;

  logic              s2_valid_q;
  logic [PW-1:0]     s2_hval_q;
  logic [COL_W-1:0]  s2_col_q;
  logic              s2_row0_q;
  logic [SLOT_W-1:0] s2_slot_q;
  logic [LINE_W-1:0] s2_line_q;
  logic [LINE_W-1:0] s2_line_new;
  logic [SUM_W-1:0]  s2_vsum;

  logic              s3_valid_q;
  logic [SUM_W-1:0]  s3_vsum_q;
  logic [PROD_W-1:0] s3_prod;

  logic              out_valid_q;
  logic [PW-1:0]     out_pixel_q;

  logic [LINE_W-1:0] line_rdata;

  assign en         = !(out_valid_q && out_stall_i);
  assign accept     = in_valid_i && en;
  assign in_stall_o = !en;

  assign col_eff  = frame_start_i ? '0 : col_pos_q;
  assign row_eff  = frame_start_i ? '0 : row_pos_q;
  assign slot_eff = frame_start_i ? '0 : slot_pos_q;
  assign col_zero = (col_eff == '0);

  always_comb begin
    col_pos_d  = col_eff + COL_W'(1);
    row_pos_d  = row_eff;
    slot_pos_d = slot_eff;
    if (col_eff == COL_W'(FRAME_SIDE - 1)) begin
      col_pos_d = '0;
      if (row_eff == COL_W'(FRAME_SIDE - 1)) begin
        row_pos_d  = '0;
        slot_pos_d = '0;
      end else begin
        row_pos_d  = row_eff + COL_W'(1);
        slot_pos_d = (slot_eff == SLOT_W'(PREV_TAPS - 1)) ? '0 : slot_eff + SLOT_W'(1);
      end
    end
  end

  always_comb begin
    hsum_d = SUM_W'(pixel_i);
    for (int k = 0; k < PREV_TAPS; k++) begin
      hsum_d = hsum_d + SUM_W'(col_zero ? pixel_i : recent_q[k]);
    end
    recent_d[0] = pixel_i;
    for (int k = 1; k < PREV_TAPS; k++) begin
      recent_d[k] = col_zero ? pixel_i : recent_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q  <= '0;
      row_pos_q  <= '0;
      slot_pos_q <= '0;
      for (int k = 0; k < PREV_TAPS; k++) begin
        recent_q[k] <= '0;
      end
    end else if (accept) begin
      col_pos_q  <= col_pos_d;
      row_pos_q  <= row_pos_d;
      slot_pos_q <= slot_pos_d;
      recent_q   <= recent_d;
    end
  end

  sbb_ram #(
    .WIDTH (LINE_W),
    .DEPTH (FRAME_SIDE)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s2_valid_q && en),
    .waddr_i (s2_col_q),
    .wdata_i (s2_line_new),
    .re_i    (en),
    .raddr_i (col_eff),
    .rdata_o (line_rdata)
  );

  assign s1_prod = PROD_W'(s1_hsum_q) * PROD_W'(RECIP);

  always_comb begin
    s2_vsum = SUM_W'(s2_hval_q);
    for (int k = 0; k < PREV_TAPS; k++) begin
      s2_vsum = s2_vsum + SUM_W'(s2_row0_q ? s2_hval_q : s2_line_q[k*PW +: PW]);
      s2_line_new[k*PW +: PW] = (s2_row0_q || (s2_slot_q == SLOT_W'(k))) ?
                                s2_hval_q : s2_line_q[k*PW +: PW];
    end
  end

  assign s3_prod = PROD_W'(s3_vsum_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_hsum_q   <= hsum_d;
      s1_col_q    <= col_eff;
      s1_row0_q   <= (row_eff == '0);
      s1_slot_q   <= slot_eff;
      s2_hval_q   <= s1_prod[RECIP_SHIFT +: PW];
      s2_col_q    <= s1_col_q;
      s2_row0_q   <= s1_row0_q;
      s2_slot_q   <= s1_slot_q;
      s2_line_q   <= line_rdata;
      s3_vsum_q   <= s2_vsum;
      out_pixel_q <= s3_prod[RECIP_SHIFT +: PW];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blurred_pixel_o = out_pixel_q;

  a_frame_start_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_start_i) |=> (s1_col_q == '0 && s1_row0_q && s1_slot_q == '0))
    else $error("frame start did not restart the position");

  a_row0_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_row0_q) |-> (s1_slot_q == '0))
    else $error("row 0 carries a nonzero line slot");

  a_slot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_pos_q <= SLOT_W'(PREV_TAPS - 1))
    else $error("line slot out of range");

  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_pos_q <= COL_W'(FRAME_SIDE - 1) && row_pos_q <= COL_W'(FRAME_SIDE - 1))
    else $error("position out of frame");

  a_out_from_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(s3_valid_q))
    else $error("result appeared without an item in the last stage");

endmodule

`default_nettype wire
